@@ src/kst_pkg.sv @@
// shared types, constants and lookup functions of the scan code translator
package kst_pkg;

  localparam int unsigned SCAN_CODES = 128;
  localparam int unsigned CODE_W     = $clog2(SCAN_CODES);
  localparam int unsigned MAP_DEPTH  = 3 * SCAN_CODES;
  localparam int unsigned MAP_AW     = $clog2(MAP_DEPTH);
  localparam int unsigned MAX_RES    = 5;
  localparam int unsigned CNT_W      = $clog2(MAX_RES + 1);
  localparam int unsigned SLOT_W     = $clog2(MAX_RES);

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_TICK  = 2'd1,
    OP_WRITE = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_CHAR    = 2'd0,
    KIND_REBOOT  = 2'd1,
    KIND_CONSOLE = 2'd2,
    KIND_DEBUG   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CFG_KEYPAD   = 2'd0,
    CFG_ARROW    = 2'd1,
    CFG_DELAY    = 2'd2,
    CFG_INTERVAL = 2'd3
  } cfg_e;

  localparam logic [1:0] SEL_NORMAL = 2'd0;
  localparam logic [1:0] SEL_SHIFT  = 2'd1;
  localparam logic [1:0] SEL_CAPS   = 2'd2;

  localparam logic [6:0] SC_LSHIFT  = 7'h2A;
  localparam logic [6:0] SC_RSHIFT  = 7'h36;
  localparam logic [6:0] SC_CTRL    = 7'h1D;
  localparam logic [6:0] SC_ALT     = 7'h38;
  localparam logic [6:0] SC_CAPS    = 7'h3A;
  localparam logic [6:0] SC_PROBE   = 7'h1A;
  localparam logic [6:0] SC_CONSOLE = 7'h61;
  localparam logic [6:0] SC_F1      = 7'h3B;
  localparam logic [6:0] SC_F10     = 7'h44;

  localparam logic [7:0] ESC_CHAR  = 8'h1B;
  localparam logic [7:0] CTRL_MASK = 8'h9F;
  localparam logic [7:0] HIGH_BIT  = 8'h80;
  localparam logic [7:0] JOY_HDR0  = 8'hFE;
  localparam logic [7:0] JOY_HDR1  = 8'hFF;
  localparam logic [7:0] PROBE_DE  = 8'h81;
  localparam logic [7:0] PROBE_FR  = 8'h5E;
  localparam logic [7:0] PROBE_ES  = 8'h27;
  localparam logic [7:0] SEQ_COUNT = 8'd36;

  localparam logic [7:0] SEQ_PLAIN [36] = '{
    8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd17, 8'd18, 8'd19, 8'd20, 8'd36, 8'd28,
    "D", "B", "C", "A", "H", "I",
    "P", "Q", "R", "S", "w", "x", "y", "m", "t", "u", "v", "l", "q", "r", "s",
    "p", "n", "M"
  };
  localparam logic [7:0] SEQ_SHIFT [36] = '{
    8'd21, 8'd23, 8'd24, 8'd25, 8'd26, 8'd31, 8'd32, 8'd33, 8'd34, 8'd35, 8'd37, 8'd29,
    8'd0, 8'd0, 8'd0, 8'd0, "J", 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0
  };

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] link_byte;
    logic [1:0] table_select;
    logic [6:0] table_index;
    logic [7:0] table_value;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              shifted;
    logic              ctrl;
    logic              alt;
    logic [7:0]        probe;
    logic              arrow_app;
    logic              keypad_app;
  } xlate_req_t;

  // 0 ordinary key, else one plus the sequence index
  function automatic logic [5:0] key_class(input logic [6:0] code);
    logic [5:0] r;
    r = 6'd0;
    if (code >= 7'd59 && code <= 7'd68) r = 6'(code - 7'd58);
    else if (code >= 7'd84 && code <= 7'd93) r = 6'(code - 7'd83);
    else if (code >= 7'd99 && code <= 7'd105) r = 6'(code - 7'd80);
    else if (code >= 7'd109 && code <= 7'd114) r = 6'(code - 7'd78);
    else begin
      case (code)
        7'd71:   r = 6'd17;
        7'd72:   r = 6'd16;
        7'd74:   r = 6'd26;
        7'd75:   r = 6'd13;
        7'd77:   r = 6'd15;
        7'd78:   r = 6'd30;
        7'd80:   r = 6'd14;
        7'd82:   r = 6'd18;
        7'd97:   r = 6'd11;
        7'd98:   r = 6'd12;
        7'd106:  r = 6'd27;
        7'd107:  r = 6'd28;
        7'd108:  r = 6'd29;
        default: r = 6'd0;
      endcase
    end
    return r;
  endfunction

  function automatic logic [7:0] pick(input logic sh, input logic [7:0] u, input logic [7:0] s,
                                      input logic [7:0] c);
    logic [7:0] r;
    r = sh ? s : u;
    return (r != 8'd0) ? r : c;
  endfunction

  // alt remap chosen by the normal keymap entry of the probe scan code
  function automatic logic [7:0] national(input logic [7:0] probe, input logic [6:0] code,
                                          input logic sh, input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (probe == PROBE_DE) begin
      case (code)
        7'h1A:   r = pick(sh, "@", "\\", c);
        7'h27:   r = pick(sh, "[", "{", c);
        7'h28:   r = pick(sh, "]", "}", c);
        default: r = c;
      endcase
    end else if (probe == PROBE_FR) begin
      case (code)
        7'h1A:   r = pick(sh, "[", "{", c);
        7'h1B:   r = pick(sh, "]", "}", c);
        7'h28:   r = pick(sh, "\\", 8'd0, c);
        7'h2B:   r = pick(sh, "@", "~", c);
        default: r = c;
      endcase
    end else if (probe == PROBE_ES) begin
      case (code)
        7'h1A:   r = pick(sh, "[", "{", c);
        7'h1B:   r = pick(sh, "]", "}", c);
        7'h28:   r = pick(sh, 8'h81, 8'h9A, c);
        7'h2B:   r = pick(sh, "#", "@", c);
        default: r = c;
      endcase
    end
    return r;
  endfunction

endpackage

@@ src/keyboard_scancode_translator.sv @@
// top level of the keyboard scan code translator
// Input channel: in_valid_i/in_ready_o carry one item (keyboard byte, tick or
// keymap write). Output channel: out_valid_o/out_ready_i carry results one per
// item handshake, the final result of an input flagged by last.
// Config port: cfg_we_i with cfg_index_i and cfg_data_i writes one register
// in the same cycle. The user must write only while the block is idle; it is not enforced.
// A key that produces results is registered together with its keymap read, then
// translated into the result list once the list is free.
// Items without results are taken at one input a cycle while in_ready_o is high; a
// key producing n results (up to 5) occupies the result sequencer while the list
// drains one entry per cycle on the output port, as long as out_ready_i is high.
// Reset clears modifiers, autorepeat and the result list and loads register
// defaults; the keymap is not cleared and must be written before use.
// When the receiver stalls the result list holds, one translated key waits
// behind it, and then in_ready_o drops until the list can be reloaded.
module keyboard_scancode_translator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  kst_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output kst_pkg::out_t out_o,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_index_i,
  input  logic [7:0]    cfg_data_i
);
  import kst_pkg::*;

  logic req_valid, req_ready;
  xlate_req_t req;
  logic map_we, map_re;
  logic [MAP_AW-1:0] map_waddr, map_raddr;
  logic [7:0] map_wdata, map_rdata;

  kst_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_i,
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .req_valid_o(req_valid), .req_ready_i(req_ready), .req_o(req),
    .map_we_o(map_we), .map_waddr_o(map_waddr), .map_wdata_o(map_wdata),
    .map_re_o(map_re), .map_raddr_o(map_raddr)
  );

  kst_ram #(.WIDTH(8), .DEPTH(MAP_DEPTH)) u_keymap (
    .clk_i, .we_i(map_we), .waddr_i(map_waddr), .wdata_i(map_wdata),
    .re_i(map_re), .raddr_i(map_raddr), .rdata_o(map_rdata)
  );

  kst_emit u_emit (
    .clk_i, .rst_ni, .req_valid_i(req_valid), .req_ready_o(req_ready), .req_i(req),
    .map_rdata_i(map_rdata), .out_valid_o, .out_ready_i, .out_o
  );
endmodule

@@ src/kst_ram.sv @@
// generic single write port ram with registered read
module kst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

@@ src/kst_ctrl.sv @@
// input decode, modifier and autorepeat state, keymap access and config registers
module kst_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  kst_pkg::in_t            in_i,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_index_i,
  input  logic [7:0]              cfg_data_i,
  output logic                    req_valid_o,
  input  logic                    req_ready_i,
  output kst_pkg::xlate_req_t     req_o,
  output logic                    map_we_o,
  output logic [kst_pkg::MAP_AW-1:0] map_waddr_o,
  output logic [7:0]              map_wdata_o,
  output logic                    map_re_o,
  output logic [kst_pkg::MAP_AW-1:0] map_raddr_o
);
  import kst_pkg::*;

  logic shl_q, shl_d, shr_q, shr_d, caps_q, caps_d, ctrl_q, ctrl_d, alt_q, alt_d;
  logic joy_q, joy_d;
  logic [6:0] rcode_q, rcode_d;
  logic [7:0] rcnt_q, rcnt_d, rdec;
  logic keypad_q, arrow_q;
  logic [7:0] delay_q, interval_q;
  logic [7:0] probe_q;
  logic accept, xlate, make, shifted;
  logic [6:0] code, xcode;
  logic [1:0] rsel;

  assign in_ready_o = req_ready_i;
  assign accept = in_valid_i && in_ready_o;
  assign make = ~in_i.link_byte[7];
  assign code = in_i.link_byte[6:0];
  assign rdec = rcnt_q - 8'd1;
  assign shifted = shl_q | shr_q;

  always_comb begin
    shl_d = shl_q; shr_d = shr_q; caps_d = caps_q; ctrl_d = ctrl_q; alt_d = alt_q;
    joy_d = joy_q; rcode_d = rcode_q; rcnt_d = rcnt_q;
    xlate = 1'b0;
    xcode = rcode_q;
    if (accept) begin
      case (in_i.op)
        OP_BYTE: begin
          if (in_i.link_byte == JOY_HDR0 || in_i.link_byte == JOY_HDR1) begin
            joy_d = 1'b1;
          end else if (joy_q) begin
            joy_d = 1'b0;
          end else if (code == SC_LSHIFT) begin
            shl_d = make;
          end else if (code == SC_RSHIFT) begin
            shr_d = make;
          end else if (code == SC_CTRL) begin
            ctrl_d = make;
          end else if (code == SC_ALT) begin
            alt_d = make;
          end else if (code == SC_CAPS) begin
            if (make) caps_d = ~caps_q;
          end else if (!make) begin
            rcnt_d = 8'd0;
          end else begin
            rcode_d = code;
            rcnt_d = delay_q;
            xlate = 1'b1;
            xcode = code;
          end
        end
        OP_TICK: begin
          if (rcnt_q != 8'd0) begin
            if (rdec != 8'd0) begin
              rcnt_d = rdec;
            end else begin
              rcnt_d = interval_q;
              xlate = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    if (shifted) rsel = SEL_SHIFT;
    else if (caps_q) rsel = SEL_CAPS;
    else rsel = SEL_NORMAL;
  end

  assign map_re_o = xlate;
  assign map_raddr_o = {rsel, xcode};
  assign map_we_o = accept && (in_i.op == OP_WRITE) && (in_i.table_select != 2'd3);
  assign map_waddr_o = {in_i.table_select, in_i.table_index};
  assign map_wdata_o = in_i.table_value;

  assign req_valid_o = xlate;
  assign req_o = '{code: xcode, shifted: shifted, ctrl: ctrl_q, alt: alt_q, probe: probe_q,
                   arrow_app: arrow_q, keypad_app: keypad_q};

  always_ff @(posedge clk_i) begin
    if (map_we_o && in_i.table_select == SEL_NORMAL && in_i.table_index == SC_PROBE) begin
      probe_q <= in_i.table_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shl_q <= 1'b0; shr_q <= 1'b0; caps_q <= 1'b0; ctrl_q <= 1'b0; alt_q <= 1'b0;
      joy_q <= 1'b0; rcode_q <= 7'd0; rcnt_q <= 8'd0;
      keypad_q <= 1'b1; arrow_q <= 1'b0; delay_q <= 8'd24; interval_q <= 8'd4;
    end else begin
      shl_q <= shl_d; shr_q <= shr_d; caps_q <= caps_d; ctrl_q <= ctrl_d; alt_q <= alt_d;
      joy_q <= joy_d; rcode_q <= rcode_d; rcnt_q <= rcnt_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_KEYPAD:   keypad_q <= cfg_data_i[0];
          CFG_ARROW:    arrow_q <= cfg_data_i[0];
          CFG_DELAY:    delay_q <= cfg_data_i;
          CFG_INTERVAL: interval_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end
endmodule

@@ src/kst_emit.sv @@
// key translation from keymap data and the result sequencer
module kst_emit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  kst_pkg::xlate_req_t req_i,
  input  logic [7:0]          map_rdata_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output kst_pkg::out_t       out_o
);
  import kst_pkg::*;

  logic pend_q;
  xlate_req_t req_q;
  logic [1:0] kind_q [MAX_RES];
  logic [7:0] val_q [MAX_RES];
  logic [CNT_W-1:0] cnt_q, idx_q;
  logic [1:0] kind_c [MAX_RES];
  logic [7:0] val_c [MAX_RES];
  logic [CNT_W-1:0] n_c;
  logic list_free, load, take, last_slot;
  logic [5:0] cls;
  logic [7:0] c, fc, f, tens, ones;

  assign last_slot = (idx_q == cnt_q - CNT_W'(1));
  assign take = out_valid_o && out_ready_i;
  assign list_free = (cnt_q == '0) || (take && last_slot);
  assign load = pend_q && list_free;
  assign req_ready_o = !pend_q || list_free;

  always_comb begin
    for (int i = 0; i < MAX_RES; i++) begin
      kind_c[i] = KIND_CHAR;
      val_c[i] = 8'd0;
    end
    n_c = '0;
    cls = key_class(req_q.code);
    f = 8'(cls) - 8'd1;
    fc = 8'd0;
    if (cls != 6'd0 && f < SEQ_COUNT) fc = req_q.shifted ? SEQ_SHIFT[f[5:0]] : SEQ_PLAIN[f[5:0]];
    if (fc >= 8'd30) tens = 8'd3;
    else if (fc >= 8'd20) tens = 8'd2;
    else if (fc >= 8'd10) tens = 8'd1;
    else tens = 8'd0;
    ones = fc - 8'(tens * 8'd10);
    c = map_rdata_i;
    if (cls == 6'd0) begin
      if (req_q.alt) c = national(req_q.probe, req_q.code, req_q.shifted, c | HIGH_BIT);
      n_c = CNT_W'(1);
      if (req_q.ctrl && c == 8'hFF) begin
        kind_c[0] = KIND_REBOOT;
      end else begin
        val_c[0] = req_q.ctrl ? (c & CTRL_MASK) : c;
      end
    end else if (req_q.ctrl && req_q.alt && req_q.code >= SC_F1 && req_q.code <= SC_F10) begin
      n_c = CNT_W'(1);
      kind_c[0] = KIND_DEBUG;
      val_c[0] = 8'(req_q.code - SC_F1) + 8'd1;
    end else if (req_q.alt && req_q.code == SC_CONSOLE) begin
      n_c = CNT_W'(1);
      kind_c[0] = KIND_CONSOLE;
    end else if (fc != 8'd0) begin
      if (f < 8'd12) begin
        val_c[0] = ESC_CHAR;
        val_c[1] = "[";
        if (tens != 8'd0) begin
          val_c[2] = tens + "0";
          val_c[3] = ones + "0";
          val_c[4] = "~";
          n_c = CNT_W'(5);
        end else begin
          val_c[2] = ones + "0";
          val_c[3] = "~";
          n_c = CNT_W'(4);
        end
      end else if (f < 8'd18) begin
        val_c[0] = ESC_CHAR;
        val_c[1] = req_q.arrow_app ? "O" : "[";
        val_c[2] = fc;
        n_c = CNT_W'(3);
      end else if (req_q.keypad_app) begin
        val_c[0] = ESC_CHAR;
        val_c[1] = "O";
        val_c[2] = fc;
        n_c = CNT_W'(3);
      end else begin
        val_c[0] = c;
        n_c = CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) req_q <= req_i;
    if (load) begin
      for (int i = 0; i < MAX_RES; i++) begin
        kind_q[i] <= kind_c[i];
        val_q[i] <= val_c[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      if (req_ready_o) pend_q <= req_valid_i;
      if (load) begin
        cnt_q <= n_c;
        idx_q <= '0;
      end else if (take) begin
        if (last_slot) cnt_q <= '0;
        idx_q <= idx_q + CNT_W'(1);
      end
    end
  end

  assign out_valid_o = (cnt_q != '0);
  assign out_o = '{kind: kind_q[idx_q[SLOT_W-1:0]], value: val_q[idx_q[SLOT_W-1:0]],
                   last: last_slot};
endmodule

@@ tb/keyboard_scancode_translator_tb.sv @@
// self-checking regression bench of the keyboard scan code translator
module keyboard_scancode_translator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kst_pkg::*;

  typedef struct {
    in_t        item;
    bit         has_exp;
    kind_e      kind;
    logic [7:0] value;
  } row_t;

  localparam logic [5:0] KEY_GROUP [128] = '{
    0,0,0,0,0,0,0,0, 0,0,0,0,0,0,0,0,
    0,0,0,0,0,0,0,0, 0,0,0,0,0,0,0,0,
    0,0,0,0,0,0,0,0, 0,0,0,0,0,0,0,0,
    0,0,0,0,0,0,0,0, 0,0,0,1,2,3,4,5,
    6,7,8,9,10,0,0,17, 16,0,26,13,0,15,30,0,
    14,0,18,0,1,2,3,4, 5,6,7,8,9,10,0,0,
    0,11,12,19,20,21,22,23, 24,25,27,28,29,31,32,33,
    34,35,36,0,0,0,0,0, 0,0,0,0,0,0,0,0
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready_o;
  in_t  in_data = '0;
  logic out_valid_o;
  logic out_ready = 1'b0;
  out_t out_o;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  keyboard_scancode_translator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_i        (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_o       (out_o),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #4 clk_i = ~clk_i;

  // translator state mirror
  logic [7:0] keymap_m [3*SCAN_CODES];
  logic       sh_l, sh_r, caps_m, ctrl_m, alt_m, joy_skip;
  logic [6:0] rep_code;
  logic [7:0] rep_count;
  logic       keypad_m, arrow_m;
  logic [7:0] delay_m, interval_m;

  out_t pending_q [$];
  out_t burst_q [$];
  int   errors = 0;
  int   tx_idle = 0;
  int   rx_stall = 0;
  int   hold_req = 0;
  int   hold_seen = 0;
  int   hold_left = 0;

  function automatic in_t key_byte(input logic [7:0] b);
    in_t it;
    it = '0;
    it.op = OP_BYTE;
    it.link_byte = b;
    return it;
  endfunction

  function automatic in_t tick_item();
    in_t it;
    it = '0;
    it.op = OP_TICK;
    return it;
  endfunction

  function automatic in_t map_write(input logic [1:0] sel, input logic [6:0] idx,
                                    input logic [7:0] val);
    in_t it;
    it = '0;
    it.op = OP_WRITE;
    it.table_select = sel;
    it.table_index = idx;
    it.table_value = val;
    return it;
  endfunction

  function automatic logic [7:0] alt_remap(input logic [6:0] code, input logic [7:0] c);
    logic [7:0] u, s, r;
    u = 8'd0;
    s = 8'd0;
    if (keymap_m[SC_PROBE] == 8'h81) begin
      case (code)
        7'h1A: begin u = "@"; s = "\\"; end
        7'h27: begin u = "["; s = "{"; end
        7'h28: begin u = "]"; s = "}"; end
        default: ;
      endcase
    end else if (keymap_m[SC_PROBE] == "^") begin
      case (code)
        7'h1A: begin u = "["; s = "{"; end
        7'h1B: begin u = "]"; s = "}"; end
        7'h28: begin u = "\\"; s = 8'd0; end
        7'h2B: begin u = "@"; s = "~"; end
        default: ;
      endcase
    end else if (keymap_m[SC_PROBE] == "'") begin
      case (code)
        7'h1A: begin u = "["; s = "{"; end
        7'h1B: begin u = "]"; s = "}"; end
        7'h28: begin u = 8'h81; s = 8'h9A; end
        7'h2B: begin u = "#"; s = "@"; end
        default: ;
      endcase
    end
    r = (sh_l || sh_r) ? s : u;
    return (r != 8'd0) ? r : c;
  endfunction

  function automatic void emit(input kind_e k, input logic [7:0] v);
    out_t o;
    o.kind = k;
    o.value = v;
    o.last = 1'b0;
    burst_q.push_back(o);
  endfunction

  function automatic void key_results(input logic [6:0] code);
    logic       shifted;
    logic [7:0] c, fc;
    int         f;
    shifted = sh_l || sh_r;
    if (shifted) c = keymap_m[SCAN_CODES + code];
    else if (caps_m) c = keymap_m[2*SCAN_CODES + code];
    else c = keymap_m[code];
    if (KEY_GROUP[code] == 0) begin
      if (alt_m) c = alt_remap(code, c | HIGH_BIT);
      if (ctrl_m && c == 8'hFF) begin
        emit(KIND_REBOOT, 8'd0);
        return;
      end
      if (ctrl_m) c &= CTRL_MASK;
      emit(KIND_CHAR, c);
      return;
    end
    if (ctrl_m && alt_m && code >= SC_F1 && code <= SC_F10) begin
      emit(KIND_DEBUG, 8'(code - SC_F1 + 1));
      return;
    end
    if (alt_m && code == SC_CONSOLE) begin
      emit(KIND_CONSOLE, 8'd0);
      return;
    end
    f = KEY_GROUP[code] - 1;
    fc = shifted ? SEQ_SHIFT[f] : SEQ_PLAIN[f];
    if (fc == 8'd0) return;
    if (f < 12) begin
      emit(KIND_CHAR, ESC_CHAR);
      emit(KIND_CHAR, "[");
      if (fc / 10 > 0) emit(KIND_CHAR, 8'(fc / 10 + 8'h30));
      emit(KIND_CHAR, 8'(fc % 10 + 8'h30));
      emit(KIND_CHAR, "~");
    end else if (f < 18) begin
      emit(KIND_CHAR, ESC_CHAR);
      emit(KIND_CHAR, arrow_m ? "O" : "[");
      emit(KIND_CHAR, fc);
    end else if (keypad_m) begin
      emit(KIND_CHAR, ESC_CHAR);
      emit(KIND_CHAR, "O");
      emit(KIND_CHAR, fc);
    end else begin
      emit(KIND_CHAR, c);
    end
  endfunction

  // updates the mirror for one accepted item, queues its results
  function automatic int translate_item(input in_t it);
    logic [6:0] code;
    logic       make;
    int         n;
    burst_q.delete();
    code = it.link_byte[6:0];
    make = ~it.link_byte[7];
    case (it.op)
      OP_BYTE: begin
        if (it.link_byte == JOY_HDR0 || it.link_byte == JOY_HDR1) joy_skip = 1'b1;
        else if (joy_skip) joy_skip = 1'b0;
        else if (code == SC_LSHIFT) sh_l = make;
        else if (code == SC_RSHIFT) sh_r = make;
        else if (code == SC_CTRL) ctrl_m = make;
        else if (code == SC_ALT) alt_m = make;
        else if (code == SC_CAPS) begin
          if (make) caps_m = ~caps_m;
        end else if (!make) rep_count = 8'd0;
        else begin
          rep_code = code;
          rep_count = delay_m;
          key_results(code);
        end
      end
      OP_TICK: begin
        if (rep_count != 8'd0) begin
          rep_count = rep_count - 8'd1;
          if (rep_count == 8'd0) begin
            key_results(rep_code);
            rep_count = interval_m;
          end
        end
      end
      OP_WRITE: begin
        if (it.table_select != 2'd3)
          keymap_m[it.table_select * SCAN_CODES + it.table_index] = it.table_value;
      end
      default: ;
    endcase
    n = burst_q.size();
    if (n > 0) burst_q[n-1].last = 1'b1;
    foreach (burst_q[i]) pending_q.push_back(burst_q[i]);
    return n;
  endfunction

  task automatic offer(input in_t it);
    if ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    void'(translate_item(it));
  endtask

  task automatic settle_and_config(input logic kp, input logic ar, input logic [7:0] dl,
                                   input logic [7:0] iv);
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= CFG_KEYPAD;
    cfg_data <= {7'd0, kp};
    @(posedge clk_i);
    cfg_index <= CFG_ARROW;
    cfg_data <= {7'd0, ar};
    @(posedge clk_i);
    cfg_index <= CFG_DELAY;
    cfg_data <= dl;
    @(posedge clk_i);
    cfg_index <= CFG_INTERVAL;
    cfg_data <= iv;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    keypad_m = kp;
    arrow_m = ar;
    delay_m = dl;
    interval_m = iv;
  endtask

  function automatic in_t random_item();
    int r;
    logic [6:0] code;
    r = $urandom_range(99);
    code = ($urandom_range(1) != 0) ? 7'($urandom_range(8'h72, 8'h3B)) : 7'($urandom_range(127));
    if (r < 35) return key_byte({1'b0, code});
    if (r < 47) return key_byte({1'b1, code});
    if (r < 57) begin
      case ($urandom_range(4))
        0: code = SC_LSHIFT;
        1: code = SC_RSHIFT;
        2: code = SC_CTRL;
        3: code = SC_ALT;
        default: code = SC_CAPS;
      endcase
      return key_byte({1'($urandom_range(1)), code});
    end
    if (r < 80) return tick_item();
    if (r < 88) begin
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(3))
          0: return map_write(SEL_NORMAL, SC_PROBE, PROBE_DE);
          1: return map_write(SEL_NORMAL, SC_PROBE, PROBE_FR);
          2: return map_write(SEL_NORMAL, SC_PROBE, PROBE_ES);
          default: return map_write(SEL_NORMAL, SC_PROBE, 8'($urandom_range(255)));
        endcase
      end
      return map_write(2'($urandom_range(3)), 7'($urandom_range(127)), 8'($urandom_range(255)));
    end
    if (r < 93) return key_byte(($urandom_range(1) != 0) ? JOY_HDR1 : JOY_HDR0);
    if (r < 96) begin
      random_item = in_t'(27'($urandom()));
      random_item.op = OP_NONE;
      return random_item;
    end
    return key_byte(8'($urandom_range(255)));
  endfunction

  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) begin
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected item kind %0d value %02h last %0d",
                                   out_o.kind, out_o.value, out_o.last);
      end else begin
        if (out_o.kind != pending_q[0].kind || out_o.value != pending_q[0].value ||
            out_o.last != pending_q[0].last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected kind %0d value %02h last %0d, got %0d %02h %0d",
                     pending_q[0].kind, pending_q[0].value, pending_q[0].last,
                     out_o.kind, out_o.value, out_o.last);
        end
        void'(pending_q.pop_front());
      end
    end
  end

  initial begin
    #20ms;
    $display("keyboard_scancode_translator regression: fail");
    $finish;
  end

  initial begin
    row_t rows [$];
    int   n;
    int   wait_cycles;
    sh_l = 0; sh_r = 0; caps_m = 0; ctrl_m = 0; alt_m = 0; joy_skip = 0;
    rep_code = '0; rep_count = '0;
    keypad_m = 1; arrow_m = 0; delay_m = 8'd24; interval_m = 8'd4;
    foreach (keymap_m[i]) keymap_m[i] = 8'd0;

    rows.push_back('{map_write(SEL_NORMAL, 7'h10, "q"), 0, KIND_CHAR, 8'd0});
    rows.push_back('{key_byte(8'h10), 1, KIND_CHAR, "q"});
    rows.push_back('{key_byte(8'h90), 0, KIND_CHAR, 8'd0});
    rows.push_back('{key_byte(8'h3B), 1, KIND_CHAR, ESC_CHAR});
    rows.push_back('{key_byte(8'h2A), 0, KIND_CHAR, 8'd0});
    rows.push_back('{key_byte(8'h44), 1, KIND_CHAR, ESC_CHAR});
    rows.push_back('{key_byte(8'h4B), 0, KIND_CHAR, 8'd0});
    rows.push_back('{key_byte(8'hAA), 0, KIND_CHAR, 8'd0});
    rows.push_back('{key_byte(JOY_HDR0), 0, KIND_CHAR, 8'd0});
    rows.push_back('{key_byte(8'h10), 0, KIND_CHAR, 8'd0});
    rows.push_back('{key_byte(JOY_HDR1), 0, KIND_CHAR, 8'd0});
    rows.push_back('{key_byte(8'h00), 0, KIND_CHAR, 8'd0});
    rows.push_back('{map_write(SEL_NORMAL, 7'h7F, 8'hFF), 0, KIND_CHAR, 8'd0});
    rows.push_back('{key_byte(8'h1D), 0, KIND_CHAR, 8'd0});
    rows.push_back('{key_byte(8'h7F), 1, KIND_REBOOT, 8'd0});
    rows.push_back('{key_byte(8'h38), 0, KIND_CHAR, 8'd0});
    rows.push_back('{key_byte(8'h3B), 1, KIND_DEBUG, 8'd1});
    rows.push_back('{key_byte(8'h44), 1, KIND_DEBUG, 8'd10});
    rows.push_back('{key_byte(8'h9D), 0, KIND_CHAR, 8'd0});
    rows.push_back('{key_byte(8'h61), 1, KIND_CONSOLE, 8'd0});
    rows.push_back('{key_byte(8'hB8), 0, KIND_CHAR, 8'd0});
    rows.push_back('{key_byte(8'h3A), 0, KIND_CHAR, 8'd0});
    rows.push_back('{key_byte(8'h48), 1, KIND_CHAR, ESC_CHAR});
    rows.push_back('{key_byte(8'h70), 1, KIND_CHAR, ESC_CHAR});
    rows.push_back('{map_write(2'd3, 7'h10, 8'h55), 0, KIND_CHAR, 8'd0});

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // load every keymap entry before any lookup can happen
    for (int s = 0; s < 3; s++)
      for (int c = 0; c < SCAN_CODES; c++)
        offer(map_write(2'(s), 7'(c), 8'($urandom_range(255))));
    offer(map_write(SEL_NORMAL, SC_PROBE, 8'h00));

    foreach (rows[i]) begin
      offer(rows[i].item);
      n = burst_q.size();
      if (rows[i].has_exp && (n == 0 || burst_q[0].kind != rows[i].kind ||
          burst_q[0].value != rows[i].value)) begin
        errors++;
        if (errors <= 10) $display("table row %0d disagrees with translation", i);
      end
    end
    offer(tick_item());
    offer(in_t'({OP_NONE, 25'h1ABCDEF}));

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: settle_and_config(1'b1, 1'b0, 8'd2, 8'd1);
        1: settle_and_config(1'b0, 1'b1, 8'd1, 8'd1);
        2: settle_and_config(1'b1, 1'b1, 8'd255, 8'd255);
        3: settle_and_config(1'b0, 1'b0, 8'd3, 8'd2);
        4: settle_and_config(1'b1, 1'b0, 8'd0, 8'd0);
        5: settle_and_config(1'b0, 1'b1, 8'd2, 8'd3);
        default: settle_and_config(1'b1, 1'b1, 8'd1, 8'd255);
      endcase
      case (ph % 4)
        0: begin tx_idle = 0; rx_stall = 0; end
        1: begin tx_idle = 59; rx_stall = 0; end
        2: begin tx_idle = 0; rx_stall = 59; end
        default: begin tx_idle = 7; rx_stall = 7; end
      endcase
      if (ph == 0) hold_req++;
      repeat (60) offer(random_item());
    end

    in_valid <= 1'b0;
    tx_idle = 0;
    rx_stall = 0;
    wait_cycles = 0;
    while (pending_q.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (20) @(posedge clk_i);
    if (errors == 0 && pending_q.size() == 0)
      $display("keyboard_scancode_translator regression: pass");
    else
      $display("keyboard_scancode_translator regression: fail");
    $finish;
  end

endmodule
